// ===== sv/vva_pkg.sv =====
// shared types, command codes and saturation helpers for the vector alu
package vva_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_SCALE   = 4'd3,
        CMD_DIV     = 4'd4,
        CMD_DOT     = 4'd5,
        CMD_CROSS   = 4'd6,
        CMD_MAG2    = 4'd7,
        CMD_MAG     = 4'd8,
        CMD_NORM    = 4'd9,
        CMD_REFLECT = 4'd10,
        CMD_COLOUR  = 4'd11
    } t_cmd;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scalar_in;
    } t_vva_in;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_scalar;
        logic [23:0]        packed_colour;
        logic               error_flag;
    } t_vva_out;

    // item record that travels down the pipe next to the arithmetic
    typedef struct packed {
        logic [3:0]       cmd;
        logic [2:0][31:0] vec;
        logic [31:0]      sc;
        logic [23:0]      col;
        logic             err;
        logic [2:0][31:0] a;
        logic [31:0]      s;
    } t_carry;

    function automatic logic signed [65:0] ext32(input logic [31:0] v);
        return $signed({{34{v[31]}}, v});
    endfunction

    function automatic logic signed [65:0] ext64(input logic [63:0] v);
        return $signed({{2{v[63]}}, v});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = Q_MAX;
        end else if (v < -66'sd2147483648) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/vva_front.sv =====
// front stages: products, sums, dot, cross, colour and reflect
module vva_front #(
    parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vva_pkg::t_vva_in i_item,
    output logic             o_valid,
    output vva_pkg::t_carry  o_rec,
    output logic [63:0]      o_sumsq
);
    import vva_pkg::*;

    localparam logic signed [32:0] ONE = 33'sd1 << FRAC_BITS;

    // stage 1: six multipliers
    t_cmd               cmd_in;
    logic signed [31:0] ma [0:5];
    logic signed [31:0] mb [0:5];
    logic signed [63:0] prod [0:5];

    logic               r_vld1;
    t_vva_in            r_item1;
    logic signed [63:0] r_prod1 [0:5];

    assign cmd_in = t_cmd'(i_item.command);

    always_comb begin
        ma[0] = i_item.a_x; mb[0] = i_item.b_x;
        ma[1] = i_item.a_y; mb[1] = i_item.b_y;
        ma[2] = i_item.a_z; mb[2] = i_item.b_z;
        // second half of the cross terms
        ma[3] = i_item.a_z; mb[3] = i_item.b_y;
        ma[4] = i_item.a_x; mb[4] = i_item.b_z;
        ma[5] = i_item.a_y; mb[5] = i_item.b_x;
        unique case (cmd_in) inside
            CMD_SCALE: begin
                mb[0] = i_item.scalar_in;
                mb[1] = i_item.scalar_in;
                mb[2] = i_item.scalar_in;
            end
            CMD_MAG2, CMD_MAG, CMD_NORM: begin
                mb[0] = i_item.a_x;
                mb[1] = i_item.a_y;
                mb[2] = i_item.a_z;
            end
            CMD_CROSS: begin
                ma[0] = i_item.a_y; mb[0] = i_item.b_z;
                ma[1] = i_item.a_z; mb[1] = i_item.b_x;
                ma[2] = i_item.a_x; mb[2] = i_item.b_y;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            prod[k] = ma[k] * mb[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= i_item;
            for (int k = 0; k < 6; k++) begin
                r_prod1[k] <= prod[k];
            end
        end
    end

    // stage 2: shift, sum and saturate
    logic signed [63:0] q [0:5];
    logic [2:0][31:0]   av;
    logic [2:0][31:0]   bv;
    logic signed [65:0] dot66;
    logic [31:0]        d;
    logic [63:0]        sumsq;
    logic [63:0]        sq_shr;
    logic [23:0]        col;
    t_carry             n_rec2;

    logic               r_vld2;
    t_carry             r_rec2;
    logic [2:0][31:0]   r_b2;
    logic signed [31:0] r_d2;
    logic [63:0]        r_sumsq2;

    assign av = {r_item1.a_z, r_item1.a_y, r_item1.a_x};
    assign bv = {r_item1.b_z, r_item1.b_y, r_item1.b_x};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            q[k] = r_prod1[k] >>> FRAC_BITS;
        end
    end

    assign dot66  = ext64(q[0]) + ext64(q[1]) + ext64(q[2]);
    assign d      = sat32(dot66);
    assign sumsq  = r_prod1[0] + r_prod1[1] + r_prod1[2];
    assign sq_shr = sumsq >> FRAC_BITS;

    // colour: clamp to [0, one], times 255, floor shift
    always_comb begin
        logic [31:0] c;
        logic [39:0] c255;
        for (int i = 0; i < 3; i++) begin
            if (av[i][31]) begin
                c = '0;
            end else if ($signed(av[i]) > ONE) begin
                c = ONE[31:0];
            end else begin
                c = av[i];
            end
            c255 = {c, 8'h00} - {8'h00, c};
            col[8*i +: 8] = 8'(c255 >> FRAC_BITS);
        end
    end

    always_comb begin
        n_rec2     = '0;
        n_rec2.cmd = r_item1.command;
        n_rec2.a   = av;
        n_rec2.s   = r_item1.scalar_in;
        case (t_cmd'(r_item1.command)) inside
            CMD_ADD: begin
                for (int i = 0; i < 3; i++) n_rec2.vec[i] = sat32(ext32(av[i]) + ext32(bv[i]));
            end
            CMD_SUB: begin
                for (int i = 0; i < 3; i++) n_rec2.vec[i] = sat32(ext32(av[i]) - ext32(bv[i]));
            end
            CMD_MUL, CMD_SCALE: begin
                for (int i = 0; i < 3; i++) n_rec2.vec[i] = sat32(ext64(q[i]));
            end
            CMD_DOT: begin
                n_rec2.sc = d;
            end
            CMD_CROSS: begin
                for (int i = 0; i < 3; i++) n_rec2.vec[i] = sat32(ext64(q[i]) - ext64(q[i+3]));
            end
            CMD_MAG2: begin
                n_rec2.sc = (sq_shr > 64'(Q_MAX)) ? Q_MAX : sq_shr[31:0];
            end
            CMD_COLOUR: begin
                n_rec2.col = col;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rec2   <= n_rec2;
            r_b2     <= bv;
            r_d2     <= d;
            r_sumsq2 <= sumsq;
        end
    end

    // stage 3: reflect products b times dot
    logic               r_vld3;
    t_carry             r_rec3;
    logic [63:0]        r_sumsq3;
    logic signed [63:0] r_prod3 [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rec3   <= r_rec2;
            r_sumsq3 <= r_sumsq2;
            for (int i = 0; i < 3; i++) begin
                r_prod3[i] <= $signed(r_b2[i]) * r_d2;
            end
        end
    end

    // stage 4: a minus twice the shifted product
    t_carry n_rec4;
    logic   r_vld4;
    t_carry r_rec4;
    logic [63:0] r_sumsq4;

    always_comb begin
        logic signed [63:0] qr;
        n_rec4 = r_rec3;
        for (int i = 0; i < 3; i++) begin
            qr = r_prod3[i] >>> FRAC_BITS;
            if (t_cmd'(r_rec3.cmd) == CMD_REFLECT) begin
                n_rec4.vec[i] = sat32(ext32(r_rec3.a[i]) - $signed({qr[63], qr, 1'b0}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rec4   <= n_rec4;
            r_sumsq4 <= r_sumsq3;
        end
    end

    assign o_valid = r_vld4;
    assign o_rec   = r_rec4;
    assign o_sumsq = r_sumsq4;

endmodule

// ===== sv/vva_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module vva_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  vva_pkg::t_carry i_rec,
    input  logic [63:0]     i_rad,
    output logic            o_valid,
    output vva_pkg::t_carry o_rec,
    output logic [31:0]     o_root
);
    import vva_pkg::*;

    localparam int STAGES = 32;

    logic        r_vld  [1:STAGES];
    t_carry      r_rec  [1:STAGES];
    logic [33:0] r_rem  [1:STAGES];
    logic [31:0] r_root [1:STAGES];
    logic [63:0] r_rad  [1:STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic        vld_in;
        t_carry      rec_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        ge;

        if (k == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rec_in  = i_rec;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_body
            assign vld_in  = r_vld[k];
            assign rec_in  = r_rec[k];
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign rad_in  = r_rad[k];
        end

        assign rem_sh = {rem_in, rad_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rec[k+1]  <= rec_in;
                r_rem[k+1]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
                r_root[k+1] <= {root_in[30:0], ge};
                r_rad[k+1]  <= {rad_in[61:0], 2'b00};
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_rec   = r_rec[STAGES];
    assign o_root  = r_root[STAGES];

endmodule

// ===== sv/vva_div.sv =====
// pipelined restoring divider, three lanes sharing one divisor
module vva_div #(
    parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  vva_pkg::t_carry           i_rec,
    input  logic [31:0]               i_div,
    input  logic [2:0][31:0]          i_num,
    output logic                      o_valid,
    output vva_pkg::t_carry           o_rec,
    output logic [2:0][31+FRAC_BITS:0] o_quo
);
    import vva_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    logic              r_vld [1:QW];
    t_carry            r_rec [1:QW];
    logic [31:0]       r_div [1:QW];
    logic [2:0][31:0]  r_rem [1:QW];
    // numerator bits shift out at the top while quotient bits enter below
    logic [2:0][QW-1:0] r_nq [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic               vld_in;
        t_carry             rec_in;
        logic [31:0]        div_in;
        logic [2:0][31:0]   rem_in;
        logic [2:0][QW-1:0] nq_in;
        logic [2:0][31:0]   rem_nx;
        logic [2:0][QW-1:0] nq_nx;

        if (k == 0) begin : g_head
            assign vld_in = i_valid;
            assign rec_in = i_rec;
            assign div_in = i_div;
            assign rem_in = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign nq_in[l] = {i_num[l], {FRAC_BITS{1'b0}}};
            end
        end else begin : g_body
            assign vld_in = r_vld[k];
            assign rec_in = r_rec[k];
            assign div_in = r_div[k];
            assign rem_in = r_rem[k];
            assign nq_in  = r_nq[k];
        end

        always_comb begin
            logic [32:0] rem_sh;
            logic        ge;
            for (int l = 0; l < 3; l++) begin
                rem_sh    = {rem_in[l], nq_in[l][QW-1]};
                ge        = rem_sh >= {1'b0, div_in};
                rem_nx[l] = ge ? 32'(rem_sh - {1'b0, div_in}) : rem_sh[31:0];
                nq_nx[l]  = {nq_in[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rec[k+1] <= rec_in;
                r_div[k+1] <= div_in;
                r_rem[k+1] <= rem_nx;
                r_nq[k+1]  <= nq_nx;
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_rec   = r_rec[QW];
    assign o_quo   = r_nq[QW];

endmodule

// ===== sv/vec3_vector_alu.sv =====
// top level of the three-component fixed-point vector alu
//
//  channel | direction | payload          | handshake
//  --------+-----------+------------------+----------------------
//  input   | in        | i_item (t_vva_in)  | i_valid / o_stall
//  output  | out       | o_item (t_vva_out) | o_valid / i_stall
//
// one transfer per cycle in each direction when nothing stalls
// from input transfer to result an item passes through 4 front
// stages (multiply, sum, reflect multiply, reflect finish), 32 square root
// stages, 32 + FRAC_BITS divider stages and one output register
// synchronous active-low reset clears all valid bits, payload is not reset
// the pipe moves as one: it holds only while a result sits in the output
// register and the sink stalls; nothing is dropped or repeated
module vec3_vector_alu #(
    parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  vva_pkg::t_vva_in  i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output vva_pkg::t_vva_out o_item
);
    import vva_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    // global advance: the output register is free or is being emptied
    logic adv;

    logic   r_out_vld;
    t_vva_out r_out;

    assign o_stall = r_out_vld && i_stall;
    assign adv     = !o_stall;

    // front: products, add/sub, dot, cross, mag2, colour, reflect
    logic        fr_vld;
    t_carry      fr_rec;
    logic [63:0] fr_sumsq;

    vva_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (fr_vld),
        .o_rec   (fr_rec),
        .o_sumsq (fr_sumsq)
    );

    // square root of the exact sum of squares, for mag and normalize
    logic        sq_vld;
    t_carry      sq_rec;
    logic [31:0] sq_root;

    vva_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fr_vld),
        .i_rec   (fr_rec),
        .i_rad   (fr_sumsq),
        .o_valid (sq_vld),
        .o_rec   (sq_rec),
        .o_root  (sq_root)
    );

    // divider setup: magnitude of numerators and divisor, zero check
    t_carry           dv_rec;
    logic [31:0]      divisor;
    logic [2:0][31:0] num;

    always_comb begin
        dv_rec  = sq_rec;
        divisor = sq_rec.s[31] ? 32'(~sq_rec.s + 32'd1) : sq_rec.s;
        if (t_cmd'(sq_rec.cmd) == CMD_NORM) begin
            // root is zero exactly when the vector is zero
            divisor = sq_root;
        end
        if (t_cmd'(sq_rec.cmd) == CMD_MAG) begin
            dv_rec.sc = sq_root[31] ? Q_MAX : sq_root;
        end
        if ((t_cmd'(sq_rec.cmd) == CMD_DIV || t_cmd'(sq_rec.cmd) == CMD_NORM)
            && divisor == '0) begin
            dv_rec.err = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            num[i] = sq_rec.a[i][31] ? 32'(~sq_rec.a[i] + 32'd1) : sq_rec.a[i];
        end
    end

    logic               dq_vld;
    t_carry             dq_rec;
    logic [2:0][QW-1:0] dq_quo;

    vva_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_vld),
        .i_rec   (dv_rec),
        .i_div   (divisor),
        .i_num   (num),
        .o_valid (dq_vld),
        .o_rec   (dq_rec),
        .o_quo   (dq_quo)
    );

    // final: sign and saturate quotients, assemble the result transfer
    logic [2:0][31:0] vec_fin;
    t_vva_out         n_out;

    always_comb begin
        logic neg;
        logic is_div;
        logic is_norm;
        is_div  = t_cmd'(dq_rec.cmd) == CMD_DIV;
        is_norm = t_cmd'(dq_rec.cmd) == CMD_NORM;
        vec_fin = dq_rec.vec;
        for (int i = 0; i < 3; i++) begin
            neg = dq_rec.a[i][31] ^ (is_div && dq_rec.s[31]);
            if (is_div || is_norm) begin
                if (dq_rec.err) begin
                    // divide by zero goes to the rail of the numerator's sign
                    if (is_norm || dq_rec.a[i] == '0) begin
                        vec_fin[i] = '0;
                    end else begin
                        vec_fin[i] = dq_rec.a[i][31] ? Q_MIN : Q_MAX;
                    end
                end else if (!neg) begin
                    vec_fin[i] = (dq_quo[i] > QW'(Q_MAX)) ? Q_MAX : dq_quo[i][31:0];
                end else begin
                    vec_fin[i] = (dq_quo[i] > QW'(Q_MIN)) ? Q_MIN
                                 : 32'(~dq_quo[i][31:0] + 32'd1);
                end
            end
        end
        n_out.res_x         = vec_fin[0];
        n_out.res_y         = vec_fin[1];
        n_out.res_z         = vec_fin[2];
        n_out.res_scalar    = dq_rec.sc;
        n_out.packed_colour = dq_rec.col;
        n_out.error_flag    = dq_rec.err;
    end

    // output register parts the pipe from the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= dq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// ===== sv/vva_checker.sv =====
// port-level checker for the vector alu and its bind
module vva_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input vva_pkg::t_vva_in  i_item,
    input logic              o_valid,
    input logic              i_stall,
    input vva_pkg::t_vva_out o_item
);
    import vva_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // the input only stalls behind a held result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with free output");

    // an error result carries no scalar and no colour
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.error_flag |->
            o_item.res_scalar == '0 && o_item.packed_colour == '0)
        else $error("error result with scalar or colour");

    // a colour result carries nothing else
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.packed_colour != '0 |->
            o_item.res_x == '0 && o_item.res_y == '0 && o_item.res_z == '0
            && !o_item.error_flag)
        else $error("colour result with vector or error");

endmodule

bind vec3_vector_alu vva_checker u_vva_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// ===== verif/vec3_vector_alu_test.sv =====
// testbench for the fixed-point vector alu, checked against a predictor
module vec3_vector_alu_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vva_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint QMAXL = 64'sd2147483647;
    localparam longint QMINL = -64'sd2147483648;

    // predicted result of one vector operation, and its helpers
    function automatic longint clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return QMAXL;
        if (v < -128'sd2147483648) return QMINL;
        return longint'(v);
    endfunction

    function automatic logic signed [127:0] fxmul(input longint x, input longint y);
        logic signed [127:0] p;
        p = 128'(x) * 128'(y);
        return p >>> FB;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic t_vva_out vec_op(input t_vva_in it);
        t_vva_out o;
        longint a[3], b[3], s, d, c;
        logic [63:0] sq, m;
        logic signed [127:0] t;
        o = '0;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
        s = it.scalar_in;
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(a[i] * a[i]);
        case (it.command)
            CMD_ADD: begin
                o.res_x = clip32(a[0] + b[0]); o.res_y = clip32(a[1] + b[1]);
                o.res_z = clip32(a[2] + b[2]);
            end
            CMD_SUB: begin
                o.res_x = clip32(a[0] - b[0]); o.res_y = clip32(a[1] - b[1]);
                o.res_z = clip32(a[2] - b[2]);
            end
            CMD_MUL: begin
                o.res_x = clip32(fxmul(a[0], b[0])); o.res_y = clip32(fxmul(a[1], b[1]));
                o.res_z = clip32(fxmul(a[2], b[2]));
            end
            CMD_SCALE: begin
                o.res_x = clip32(fxmul(a[0], s)); o.res_y = clip32(fxmul(a[1], s));
                o.res_z = clip32(fxmul(a[2], s));
            end
            CMD_DIV: begin
                // divide by zero saturates by sign of the numerator
                if (s == 0) begin
                    o.error_flag = 1'b1;
                    o.res_x = a[0] > 0 ? QMAXL : a[0] < 0 ? QMINL : 0;
                    o.res_y = a[1] > 0 ? QMAXL : a[1] < 0 ? QMINL : 0;
                    o.res_z = a[2] > 0 ? QMAXL : a[2] < 0 ? QMINL : 0;
                end else begin
                    o.res_x = clip32((a[0] <<< FB) / s); o.res_y = clip32((a[1] <<< FB) / s);
                    o.res_z = clip32((a[2] <<< FB) / s);
                end
            end
            CMD_DOT: o.res_scalar = clip32(fxmul(a[0], b[0]) + fxmul(a[1], b[1])
                                           + fxmul(a[2], b[2]));
            CMD_CROSS: begin
                o.res_x = clip32(fxmul(a[1], b[2]) - fxmul(a[2], b[1]));
                o.res_y = clip32(fxmul(a[2], b[0]) - fxmul(a[0], b[2]));
                o.res_z = clip32(fxmul(a[0], b[1]) - fxmul(a[1], b[0]));
            end
            CMD_MAG2: begin
                sq = sq >> FB;
                o.res_scalar = sq > 64'(QMAXL) ? QMAXL : sq;
            end
            CMD_MAG: begin
                m = root64(sq);
                o.res_scalar = m > 64'(QMAXL) ? QMAXL : m;
            end
            CMD_NORM: begin
                // zero vector flags an error, result stays zero
                if (sq == 0) begin
                    o.error_flag = 1'b1;
                end else begin
                    m = root64(sq);
                    o.res_x = clip32((a[0] <<< FB) / longint'(m));
                    o.res_y = clip32((a[1] <<< FB) / longint'(m));
                    o.res_z = clip32((a[2] <<< FB) / longint'(m));
                end
            end
            CMD_REFLECT: begin
                d = clip32(fxmul(a[0], b[0]) + fxmul(a[1], b[1]) + fxmul(a[2], b[2]));
                o.res_x = clip32(a[0] - 2 * fxmul(b[0], d));
                o.res_y = clip32(a[1] - 2 * fxmul(b[1], d));
                o.res_z = clip32(a[2] - 2 * fxmul(b[2], d));
            end
            CMD_COLOUR: begin
                for (int i = 0; i < 3; i++) begin
                    c = a[i];
                    if (c > (64'sd1 <<< FB)) c = 64'sd1 <<< FB;
                    if (c < 0) c = 0;
                    o.packed_colour[8*i +: 8] = 8'((c * 255) >>> FB);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    class vec_scoreboard;
        t_vva_out pending[$];
        int errors;
        function void note_input(t_vva_in it);
            pending.insert(pending.size(), vec_op(it));
        endfunction
        function void check_result(t_vva_out got);
            t_vva_out want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.res_x !== want.res_x)
                $display("%0t res_x exp %h got %h", $time, want.res_x, got.res_x);
            if (got.res_y !== want.res_y)
                $display("%0t res_y exp %h got %h", $time, want.res_y, got.res_y);
            if (got.res_z !== want.res_z)
                $display("%0t res_z exp %h got %h", $time, want.res_z, got.res_z);
            if (got.res_scalar !== want.res_scalar)
                $display("%0t res_scalar exp %h got %h", $time, want.res_scalar,
                         got.res_scalar);
            if (got.packed_colour !== want.packed_colour)
                $display("%0t packed_colour exp %h got %h", $time, want.packed_colour,
                         got.packed_colour);
            if (got.error_flag !== want.error_flag)
                $display("%0t error_flag exp %b got %b", $time, want.error_flag,
                         got.error_flag);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic o_stall, o_valid;
    t_vva_in i_item = '0;
    t_vva_out o_item;
    vec_scoreboard sb = new();
    bit tail_phase = 0;       // no idling in the last part
    bit hold_done = 0;
    int accepted = 0;

    vec3_vector_alu dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // hard limit on the run
    initial begin
        #5ms;
        $display("vec3_vector_alu: mismatch");
        $finish;
    end

    // result side: sample and check results, and note accepted inputs
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_input(i_item);
            accepted++;
        end
    end

    // sink stalling: one long hold early on, then random bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        while (accepted < 30) @(posedge i_clk);
        i_stall <= 1;
        n = 0;
        while (n < 300) begin
            @(posedge i_clk);
            n++;
        end
        i_stall <= 0;
        hold_done = 1;
        forever begin
            n = $urandom_range(1, 19);
            repeat (n) @(posedge i_clk);
            if (!tail_phase && $urandom_range(0, 2) == 0) begin
                i_stall <= 1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 0;
            end
        end
    end

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 32'h3_0000)));
            3: return 0;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input t_vva_in it);
        i_item <= it;
        i_valid <= 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_gap();
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    function automatic t_vva_in mk(input t_cmd c, input logic [31:0] ax, ay, az, bx, by,
                                   bz, s);
        t_vva_in it;
        it.command = c; it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_x = bx; it.b_y = by; it.b_z = bz; it.scalar_in = s;
        return it;
    endfunction

    initial begin
        t_vva_in it;
        int wait_cnt;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: each operation, extremes and the error cases
        for (int c = 0; c < 12; c++)
            send(mk(t_cmd'(c), 32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000));
        send(mk(CMD_DIV, 32'h0002_0000, 32'hfff0_0000, 0, 0, 0, 0, 0));
        send(mk(CMD_NORM, 0, 0, 0, 1, 2, 3, 4));
        send(mk(CMD_NORM, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0));
        send(mk(CMD_COLOUR, 32'h0000_8000, 32'h0002_0000, 32'hffff_ffff, 0, 0, 0, 0));
        send(mk(CMD_COLOUR, 32'h0001_0000, 0, 32'h0000_0001, 0, 0, 0, 0));
        send(mk(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
        send(mk(CMD_REFLECT, 32'h0001_0000, 32'hffff_0000, 0, 0, 32'h0001_0000, 0, 0));
        it = '1;
        send(it);                     // unused command code, all bits high
        it = '0; it.command = 4'hc;
        send(it);
        // random stream
        for (int k = 0; k < 750; k++) begin
            if (k > 650) tail_phase = 1;
            it.command = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                                      : 4'($urandom_range(0, 11));
            it.a_x = rnd_val(); it.a_y = rnd_val(); it.a_z = rnd_val();
            it.b_x = rnd_val(); it.b_y = rnd_val(); it.b_z = rnd_val();
            it.scalar_in = rnd_val();
            send(it);
            send_gap();
        end
        i_valid <= 0;
        tail_phase = 1;
        wait_cnt = 0;
        while ((sb.pending.size() != 0 || !hold_done) && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("vec3_vector_alu: match");
        else
            $display("vec3_vector_alu: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/vva_pkg.sv
sv/vva_front.sv
sv/vva_sqrt.sv
sv/vva_div.sv
sv/vec3_vector_alu.sv
sv/vva_checker.sv
verif/vec3_vector_alu_test.sv
